[design/fzpid_pkg.sv]
// ----------------------------------------------------------------------------
// fzpid_pkg: shared types and constants of the fuzzy PID gain adjuster
// Holds the rule tables for Kp, Ki and Kd, the rule index structures and the
// constants of the final divide-by-three stage.
// ----------------------------------------------------------------------------
package fzpid_pkg;

    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int OUT_W   = 17;
    localparam int SEG_W   = 3;
    localparam int RULE_W  = 3;
    localparam int NSETS   = 7;
    localparam int NSTAGE  = 5;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    // Highest segment start; a value on the upper edge stays in this segment.
    localparam logic [SEG_W-1:0] SEG_MAX = 3'd5;

    // Floor division by three of the scaled sum, done as a reciprocal multiply.
    localparam int SH_W        = 18;
    localparam int DIV_IN_W    = 19;
    localparam int DIV_SHIFT   = 20;
    localparam logic [DIV_IN_W-1:0] DIV_OFFSET = 19'd196608;
    localparam logic [DIV_IN_W-1:0] DIV_RECIP  = 19'd349526;
    localparam logic [SH_W-1:0]     OUT_BIAS   = 18'd65536;

    typedef logic [SEG_W-1:0] seg_t;
    typedef logic signed [RULE_W-1:0] rule_val_t;

    typedef struct packed {
        seg_t e_lo;
        seg_t e_hi;
        seg_t d_lo;
        seg_t d_hi;
    } rule_idx_t;

    typedef struct packed {
        rule_val_t ll;
        rule_val_t lh;
        rule_val_t hl;
        rule_val_t hh;
    } rule_sel_t;

    typedef enum logic [1:0] {
        GAIN_KP = 2'd0,
        GAIN_KI = 2'd1,
        GAIN_KD = 2'd2
    } gain_sel_t;

    localparam int KP_TAB [NSETS][NSETS] = '{
        '{ 3,  3,  2,  2,  1,  0,  0},
        '{ 3,  3,  2,  1,  1,  0, -1},
        '{ 2,  2,  2,  1,  0, -1, -1},
        '{ 2,  2,  1,  0, -1, -2, -2},
        '{ 1,  1,  0, -1, -1, -2, -2},
        '{ 1,  0, -1, -2, -2, -2, -3},
        '{ 0,  0, -2, -2, -2, -3, -3}
    };

    localparam int KI_TAB [NSETS][NSETS] = '{
        '{-3, -3, -2, -2, -1,  0,  0},
        '{-3, -3, -2, -1, -1,  0,  0},
        '{-3, -2, -1, -1,  0,  1,  1},
        '{-2, -2, -1,  0,  1,  2,  2},
        '{-1, -1,  0,  1,  1,  2,  3},
        '{ 0,  0,  1,  1,  2,  3,  3},
        '{ 0,  0,  1,  2,  2,  3,  3}
    };

    localparam int KD_TAB [NSETS][NSETS] = '{
        '{ 1, -1, -3, -3, -3, -2,  1},
        '{ 1, -1, -3, -2, -2, -1,  0},
        '{ 0, -1, -2, -2, -1, -1,  0},
        '{ 0, -1, -1, -1, -1, -1,  0},
        '{ 0,  0,  0,  0,  0,  0,  0},
        '{ 3, -1,  1,  1,  1,  1,  3},
        '{ 3,  2,  2,  2,  1,  1,  3}
    };

    function automatic rule_val_t rule_lookup(gain_sel_t sel, seg_t e, seg_t d);
        rule_val_t val;
        val = '0;
        if (e < seg_t'(NSETS) && d < seg_t'(NSETS))
        begin
            case (sel)
                GAIN_KP: val = rule_val_t'(KP_TAB[e][d]);
                GAIN_KI: val = rule_val_t'(KI_TAB[e][d]);
                GAIN_KD: val = rule_val_t'(KD_TAB[e][d]);
                default: val = '0;
            endcase
        end
        return val;
    endfunction

endpackage

[design/fzpid_sample_if.sv]
// ----------------------------------------------------------------------------
// fzpid_sample_if: error sample channel
// Carries the current and previous control error with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fzpid_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] this_error;
    logic signed [15:0] last_error;

    modport source (output valid, output this_error, output last_error, input ready);
    modport sink   (input valid, input this_error, input last_error, output ready);
endinterface

[design/fzpid_gains_if.sv]
// ----------------------------------------------------------------------------
// fzpid_gains_if: gain correction channel
// Carries the three gain corrections with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fzpid_gains_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] kp_adj;
    logic signed [16:0] ki_adj;
    logic signed [16:0] kd_adj;

    modport source (output valid, output kp_adj, output ki_adj, output kd_adj,
                    input ready);
    modport sink   (input valid, input kp_adj, input ki_adj, input kd_adj,
                    output ready);
endinterface

[design/fzpid_cfg_if.sv]
// ----------------------------------------------------------------------------
// fzpid_cfg_if: configuration write channel
// Carries the quantization gain with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fzpid_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] quant_gain;

    modport source (output valid, output quant_gain, input ready);
    modport sink   (input valid, input quant_gain, output ready);
endinterface

[design/fzpid_fuzzify.sv]
// ----------------------------------------------------------------------------
// fzpid_fuzzify: quantizer and triangular membership
// Stage one scales the operand by the gain, stage two saturates it to the
// universe -3..3 and splits it into a segment index and two memberships.
// ----------------------------------------------------------------------------
module fzpid_fuzzify #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [16:0]     operand,
    input  logic [23:0]            gain,
    output fzpid_pkg::seg_t        seg,
    output logic [FRAC_BITS:0]     mem_lo,
    output logic [FRAC_BITS:0]     mem_hi
);
    import fzpid_pkg::*;

    localparam int PROD_W = 17 + GAIN_W + 1;
    localparam int U_W    = FRAC_BITS + 3;
    localparam logic signed [PROD_W-1:0] LIM = PROD_W'(64'sd3 <<< FRAC_BITS);
    localparam logic [U_W-1:0]           BIAS = U_W'(64'd3 << FRAC_BITS);
    localparam logic [FRAC_BITS:0]       ONE  = (FRAC_BITS+1)'(64'd1 << FRAC_BITS);

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [U_W-1:0]    sat_val;
    logic [U_W-1:0]           shifted;
    seg_t                     seg_raw;
    seg_t                     seg_reg, seg_next;
    logic [FRAC_BITS:0]       frac;
    logic [FRAC_BITS:0]       mlo_reg, mlo_next, mhi_reg, mhi_next;

    assign prod_next = operand * $signed({1'b0, gain});

    always_comb
    begin
        if (prod_reg > LIM)
            sat_val = U_W'(LIM);
        else if (prod_reg < -LIM)
            sat_val = U_W'(-LIM);
        else
            sat_val = U_W'(prod_reg);
        shifted = $unsigned(sat_val) + BIAS;
        seg_raw = shifted[U_W-1:FRAC_BITS];
        // Only the upper edge of the universe lands past the last segment.
        if (seg_raw > SEG_MAX)
        begin
            seg_next = SEG_MAX;
            frac     = ONE;
        end
        else
        begin
            seg_next = seg_raw;
            frac     = {1'b0, shifted[FRAC_BITS-1:0]};
        end
        mhi_next = frac;
        mlo_next = ONE - frac;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            seg_reg  <= seg_next;
            mlo_reg  <= mlo_next;
            mhi_reg  <= mhi_next;
        end
    end

    assign seg    = seg_reg;
    assign mem_lo = mlo_reg;
    assign mem_hi = mhi_reg;

endmodule

[design/fzpid_infer.sv]
// ----------------------------------------------------------------------------
// fzpid_infer: rule firing strengths
// Forms the four products of error and change-of-error memberships.
// ----------------------------------------------------------------------------
module fzpid_infer #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [FRAC_BITS:0]     e_lo,
    input  logic [FRAC_BITS:0]     e_hi,
    input  logic [FRAC_BITS:0]     d_lo,
    input  logic [FRAC_BITS:0]     d_hi,
    output logic [2*FRAC_BITS:0]   w_ll,
    output logic [2*FRAC_BITS:0]   w_lh,
    output logic [2*FRAC_BITS:0]   w_hl,
    output logic [2*FRAC_BITS:0]   w_hh
);
    localparam int FULL_W = 2*FRAC_BITS + 2;
    localparam int PW     = 2*FRAC_BITS + 1;

    logic [FULL_W-1:0] full_ll, full_lh, full_hl, full_hh;
    logic [PW-1:0]     ll_reg, lh_reg, hl_reg, hh_reg;

    // Memberships never exceed one, so each product fits below 2^(2F+1).
    assign full_ll = e_lo * d_lo;
    assign full_lh = e_lo * d_hi;
    assign full_hl = e_hi * d_lo;
    assign full_hh = e_hi * d_hi;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= full_ll[PW-1:0];
            lh_reg <= full_lh[PW-1:0];
            hl_reg <= full_hl[PW-1:0];
            hh_reg <= full_hh[PW-1:0];
        end
    end

    assign w_ll = ll_reg;
    assign w_lh = lh_reg;
    assign w_hl = hl_reg;
    assign w_hh = hh_reg;

endmodule

[design/fzpid_defuzz.sv]
// ----------------------------------------------------------------------------
// fzpid_defuzz: rule blend and scaling for one gain
// Looks up four rule entries, sums the weighted entries, and floors the sum
// divided by three into Q2.15.
// ----------------------------------------------------------------------------
module fzpid_defuzz #(
    parameter int                   FRAC_BITS = 16,
    parameter fzpid_pkg::gain_sel_t SEL       = fzpid_pkg::GAIN_KP
) (
    input  logic                       clk,
    input  logic                       en,
    input  fzpid_pkg::rule_idx_t       idx,
    input  logic [2*FRAC_BITS:0]       w_ll,
    input  logic [2*FRAC_BITS:0]       w_lh,
    input  logic [2*FRAC_BITS:0]       w_hl,
    input  logic [2*FRAC_BITS:0]       w_hh,
    output logic signed [16:0]         delta
);
    import fzpid_pkg::*;

    localparam int SW   = 2*FRAC_BITS + 4;
    localparam int KSH  = 2*FRAC_BITS - 15;
    localparam int DP_W = 2*DIV_IN_W;

    rule_sel_t                sel_reg, sel_next;
    logic signed [SW-1:0]     t_ll, t_lh, t_hl, t_hh, sum;
    logic [DIV_IN_W-1:0]      x_reg, x_next;
    logic [DP_W-1:0]          dprod;
    logic [SH_W-1:0]          quot;
    logic signed [OUT_W-1:0]  delta_reg, delta_next;

    always_comb
    begin
        sel_next.ll = rule_lookup(SEL, idx.e_lo, idx.d_lo);
        sel_next.lh = rule_lookup(SEL, idx.e_lo, idx.d_hi);
        sel_next.hl = rule_lookup(SEL, idx.e_hi, idx.d_lo);
        sel_next.hh = rule_lookup(SEL, idx.e_hi, idx.d_hi);
    end

    assign t_ll = $signed({1'b0, w_ll}) * sel_reg.ll;
    assign t_lh = $signed({1'b0, w_lh}) * sel_reg.lh;
    assign t_hl = $signed({1'b0, w_hl}) * sel_reg.hl;
    assign t_hh = $signed({1'b0, w_hh}) * sel_reg.hh;
    assign sum  = t_ll + t_lh + t_hl + t_hh;

    // Floor by the power-of-two part first, then bias the value positive so
    // that the reciprocal multiply below floors correctly for negative sums.
    assign x_next = DIV_IN_W'($signed(sum[KSH +: SH_W])) + DIV_OFFSET;

    assign dprod      = x_reg * DIV_RECIP;
    assign quot       = dprod[DIV_SHIFT +: SH_W];
    assign delta_next = OUT_W'(quot - OUT_BIAS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg   <= sel_next;
            x_reg     <= x_next;
            delta_reg <= delta_next;
        end
    end

    assign delta = delta_reg;

endmodule

[design/fuzzy_pid_gain_adjust.sv]
// ----------------------------------------------------------------------------
// fuzzy_pid_gain_adjust: fuzzy self-tuning PID gain corrections
// Top level: five-stage pipeline from error samples to Kp, Ki, Kd corrections.
// ----------------------------------------------------------------------------
// The block accepts one error request per clock cycle and returns its three
// gain corrections in request order, through five register stages: gain
// multiply, saturation and membership, membership products with rule lookup,
// weighted sum, and the reciprocal multiply of the divide by three. When the
// result side stalls, the whole pipeline holds and the sample side deasserts
// ready. The quantization gain is written through the configuration channel,
// which is always ready, and should only be changed while no request is in
// flight.
module fuzzy_pid_gain_adjust #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fzpid_sample_if.sink         sample,
    fzpid_gains_if.source        gains,
    fzpid_cfg_if.sink            cfg
);
    import fzpid_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(64'd1 << FRAC_BITS);

    logic [GAIN_W-1:0]  gain_reg;
    logic [NSTAGE-1:0]  vld_reg, vld_next;
    logic               en;
    logic signed [16:0] err_twice, err_diff;
    seg_t               e_seg, d_seg;
    logic [FRAC_BITS:0] e_mlo, e_mhi, d_mlo, d_mhi;
    rule_idx_t          idx;
    logic [2*FRAC_BITS:0] w_ll, w_lh, w_hl, w_hh;

    assign en        = !vld_reg[NSTAGE-1] || gains.ready;
    assign vld_next  = {vld_reg[NSTAGE-2:0], sample.valid};
    assign sample.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            gain_reg <= GAIN_RESET;
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            if (cfg.valid)
                gain_reg <= cfg.quant_gain;
        end
    end

    assign err_twice = {sample.this_error, 1'b0};
    assign err_diff  = 17'(sample.this_error) - 17'(sample.last_error);

    fzpid_fuzzify #(.FRAC_BITS(FRAC_BITS)) u_fuzz_err (
        .clk     (clk),
        .en      (en),
        .operand (err_twice),
        .gain    (gain_reg),
        .seg     (e_seg),
        .mem_lo  (e_mlo),
        .mem_hi  (e_mhi)
    );

    fzpid_fuzzify #(.FRAC_BITS(FRAC_BITS)) u_fuzz_dif (
        .clk     (clk),
        .en      (en),
        .operand (err_diff),
        .gain    (gain_reg),
        .seg     (d_seg),
        .mem_lo  (d_mlo),
        .mem_hi  (d_mhi)
    );

    always_comb
    begin
        idx.e_lo = e_seg;
        idx.e_hi = e_seg + seg_t'(1);
        idx.d_lo = d_seg;
        idx.d_hi = d_seg + seg_t'(1);
    end

    fzpid_infer #(.FRAC_BITS(FRAC_BITS)) u_infer (
        .clk  (clk),
        .en   (en),
        .e_lo (e_mlo),
        .e_hi (e_mhi),
        .d_lo (d_mlo),
        .d_hi (d_mhi),
        .w_ll (w_ll),
        .w_lh (w_lh),
        .w_hl (w_hl),
        .w_hh (w_hh)
    );

    fzpid_defuzz #(.FRAC_BITS(FRAC_BITS), .SEL(GAIN_KP)) u_defuzz_kp (
        .clk (clk), .en (en), .idx (idx),
        .w_ll (w_ll), .w_lh (w_lh), .w_hl (w_hl), .w_hh (w_hh),
        .delta (gains.kp_adj)
    );

    fzpid_defuzz #(.FRAC_BITS(FRAC_BITS), .SEL(GAIN_KI)) u_defuzz_ki (
        .clk (clk), .en (en), .idx (idx),
        .w_ll (w_ll), .w_lh (w_lh), .w_hl (w_hl), .w_hh (w_hh),
        .delta (gains.ki_adj)
    );

    fzpid_defuzz #(.FRAC_BITS(FRAC_BITS), .SEL(GAIN_KD)) u_defuzz_kd (
        .clk (clk), .en (en), .idx (idx),
        .w_ll (w_ll), .w_lh (w_lh), .w_hl (w_hl), .w_hh (w_hh),
        .delta (gains.kd_adj)
    );

    assign gains.valid = vld_reg[NSTAGE-1];

    // The two memberships of each quantity always add up to one.
    a_err_partition: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> ({1'b0, e_mlo} + {1'b0, e_mhi}) == {1'b0, ONE})
        else $error("error memberships do not sum to one");

    a_dif_partition: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> ({1'b0, d_mlo} + {1'b0, d_mhi}) == {1'b0, ONE})
        else $error("change memberships do not sum to one");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (e_seg <= SEG_MAX) && (d_seg <= SEG_MAX))
        else $error("segment index beyond the last segment");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        gains.valid |-> (gains.kp_adj >= -17'sd32768) && (gains.kp_adj <= 17'sd32768)
                     && (gains.ki_adj >= -17'sd32768) && (gains.ki_adj <= 17'sd32768)
                     && (gains.kd_adj >= -17'sd32768) && (gains.kd_adj <= 17'sd32768))
        else $error("gain correction out of range");

endmodule
